/* rtl/lbrc_pkg.sv */
package lbrc_pkg;

	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_STEADY = 2'd1;
	localparam logic [1:0] OP_BREATH = 2'd2;

	localparam int unsigned CHAN_W  = 8;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned PROD_W  = CHAN_W + COUNT_W;

	// Channel order used by the sequencer when it walks the colour.
	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [CHAN_W-1:0]  red_in;
		logic [CHAN_W-1:0]  green_in;
		logic [CHAN_W-1:0]  blue_in;
		logic [COUNT_W-1:0] ramp_len_in;
	} cmd_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red_out;
		logic [CHAN_W-1:0] green_out;
		logic [CHAN_W-1:0] blue_out;
	} pix_t;

	typedef struct packed {
		logic               start;
		logic [CHAN_W-1:0]  level;
		logic [COUNT_W-1:0] count;
		logic [COUNT_W-1:0] length;
	} scl_req_t;

	typedef struct packed {
		logic              done;
		logic [CHAN_W-1:0] quot;
	} scl_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCALE,
		ST_PUSH
	} seq_state_t;

endpackage

/* rtl/lbrc_scaler.sv */
module lbrc_scaler (
	input  logic              clk,
	input  logic              arst_n,
	input  lbrc_pkg::scl_req_t req,
	output lbrc_pkg::scl_rsp_t rsp
);
	import lbrc_pkg::*;

	logic                busy_q;
	logic [2:0]          step_q;
	logic [COUNT_W-1:0]  rem_q;
	logic [CHAN_W-1:0]   low_q;
	logic [PROD_W-1:0]   prod;
	logic [COUNT_W:0]    trial;
	logic [COUNT_W:0]    diff;
	logic                qbit;

	// The caller keeps count <= length, so level*count < 256*length and the
	// quotient fits in eight bits: eight restoring steps are enough.
	assign prod  = PROD_W'(req.level) * PROD_W'(req.count);
	assign trial = {rem_q, low_q[CHAN_W-1]};
	assign diff  = trial - {1'b0, req.length};
	assign qbit  = (trial >= {1'b0, req.length});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 3'd1;
			if (step_q == 3'd7) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= prod[PROD_W-1:CHAN_W];
			low_q <= prod[CHAN_W-1:0];
		end else if (busy_q) begin
			rem_q <= qbit ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
			low_q <= {low_q[CHAN_W-2:0], qbit};
		end
	end

	assign rsp.done = busy_q && (step_q == 3'd7);
	assign rsp.quot = {low_q[CHAN_W-2:0], qbit};

endmodule

/* rtl/led_breath_ramp_controller_top.sv */
// Steady command: the word is registered, then put on pix once the output is free.
// Tick that steps the ramp: a load and multiply step plus eight divide steps
// per channel on one shared serial divider, three channels, then a push step
// that waits until the output is free before the word appears on pix.
// Breathing command, non-stepping tick and unused opcode: no word.
// Commands are taken one at a time; reset clears all ramp state to zero.
module led_breath_ramp_controller_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  lbrc_pkg::cmd_t cmd,
	output logic           pix_valid,
	input  logic           pix_ready,
	output lbrc_pkg::pix_t pix
);
	import lbrc_pkg::*;

	seq_state_t         state_q;
	seq_state_t         state_nxt;
	logic [CHAN_W-1:0]  base_red_q;
	logic [CHAN_W-1:0]  base_green_q;
	logic [CHAN_W-1:0]  base_blue_q;
	logic [COUNT_W-1:0] ramp_count_q;
	logic [COUNT_W-1:0] ramp_length_q;
	logic               falling_q;
	logic               breathing_q;
	logic [1:0]         ch_q;
	logic               launch_q;
	pix_t               res_q;
	pix_t               pix_q;
	logic               pix_valid_q;
	logic               accept;
	logic               step_up;
	logic               step_down;
	logic               out_free;
	scl_req_t           scl_req;
	scl_rsp_t           scl_rsp;

	assign accept    = cmd_valid && cmd_ready;
	assign step_up   = breathing_q && !falling_q && (ramp_count_q < ramp_length_q);
	assign step_down = breathing_q && falling_q && (ramp_count_q != '0);
	assign out_free  = !pix_valid_q || pix_ready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && cmd.opcode == OP_STEADY) begin
					state_nxt = ST_PUSH;
				end else if (accept && cmd.opcode == OP_TICK && (step_up || step_down)) begin
					state_nxt = ST_SCALE;
				end
			end
			ST_SCALE: begin
				if (scl_rsp.done && ch_q == CH_BLUE) begin
					state_nxt = ST_PUSH;
				end
			end
			ST_PUSH: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready = (state_q == ST_IDLE);
		scl_req.start  = (state_q == ST_SCALE) && launch_q;
		scl_req.count  = ramp_count_q;
		scl_req.length = ramp_length_q;
		unique case (ch_q)
			CH_RED:   scl_req.level = base_red_q;
			CH_GREEN: scl_req.level = base_green_q;
			default:  scl_req.level = base_blue_q;
		endcase
	end

	lbrc_scaler u_scaler (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (scl_req),
		.rsp    (scl_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			base_red_q    <= '0;
			base_green_q  <= '0;
			base_blue_q   <= '0;
			ramp_count_q  <= '0;
			ramp_length_q <= '0;
			falling_q     <= 1'b0;
			breathing_q   <= 1'b0;
			ch_q          <= CH_RED;
			launch_q      <= 1'b0;
			pix_valid_q   <= 1'b0;
		end else begin
			state_q  <= state_nxt;
			launch_q <= 1'b0;
			if (accept) begin
				unique case (cmd.opcode)
					OP_STEADY: breathing_q <= 1'b0;
					OP_BREATH: begin
						base_red_q    <= cmd.red_in;
						base_green_q  <= cmd.green_in;
						base_blue_q   <= cmd.blue_in;
						ramp_length_q <= cmd.ramp_len_in;
						ramp_count_q  <= '0;
						falling_q     <= 1'b0;
						breathing_q   <= 1'b1;
					end
					OP_TICK: begin
						if (step_up || step_down) begin
							ch_q     <= CH_RED;
							launch_q <= 1'b1;
						end else if (breathing_q) begin
							// The ramp hit an end: turn around without a word.
							falling_q <= !falling_q;
						end
					end
					default: ;
				endcase
			end
			if (state_q == ST_SCALE && scl_rsp.done) begin
				if (ch_q == CH_BLUE) begin
					// Scaling used the old count; step it only now.
					ramp_count_q <= falling_q ? ramp_count_q - 16'd1
					                          : ramp_count_q + 16'd1;
				end else begin
					ch_q     <= ch_q + 2'd1;
					launch_q <= 1'b1;
				end
			end
			if (state_q == ST_PUSH && out_free) begin
				pix_valid_q <= 1'b1;
			end else if (pix_ready) begin
				pix_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cmd.opcode == OP_STEADY) begin
			res_q.red_out   <= cmd.red_in;
			res_q.green_out <= cmd.green_in;
			res_q.blue_out  <= cmd.blue_in;
		end
		if (state_q == ST_SCALE && scl_rsp.done) begin
			unique case (ch_q)
				CH_RED:   res_q.red_out   <= scl_rsp.quot;
				CH_GREEN: res_q.green_out <= scl_rsp.quot;
				default:  res_q.blue_out  <= scl_rsp.quot;
			endcase
		end
		if (state_q == ST_PUSH && out_free) begin
			pix_q <= res_q;
		end
	end

	assign pix_valid = pix_valid_q;
	assign pix       = pix_q;

endmodule

/* rtl/lbrc_checker.sv */
module lbrc_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_valid,
	input logic           cmd_ready,
	input lbrc_pkg::cmd_t cmd,
	input logic           pix_valid,
	input logic           pix_ready,
	input lbrc_pkg::pix_t pix
);
	import lbrc_pkg::*;

	logic acc;

	assign acc = cmd_valid && cmd_ready;

	// A word that is not taken stays on the port unchanged.
	a_pix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=> pix_valid && $stable(pix))
		else $error("pix word changed or dropped while stalled");

	// A breathing command never produces a word.
	a_breath_silent: assert property (@(posedge clk) disable iff (!arst_n)
		acc && cmd.opcode == OP_BREATH |=> !$rose(pix_valid))
		else $error("breathing command produced a word");

	// A tick either needs the serial divider or produces no word, so no word can follow it at once.
	a_tick_not_instant: assert property (@(posedge clk) disable iff (!arst_n)
		acc && cmd.opcode == OP_TICK |=> !$rose(pix_valid))
		else $error("tick word appeared too early");

	// After a steady command is taken, cmd_ready must drop while its word is pending.
	a_steady_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc && cmd.opcode == OP_STEADY |=> !cmd_ready)
		else $error("command taken while a steady word is pending");

endmodule

bind led_breath_ramp_controller_top lbrc_checker u_lbrc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_ready (cmd_ready),
	.cmd       (cmd),
	.pix_valid (pix_valid),
	.pix_ready (pix_ready),
	.pix       (pix)
);

/* verif/tb_led_breath_ramp_controller_top.sv */
module tb_led_breath_ramp_controller_top;
	import lbrc_pkg::*;

	// Opcode three has no name in the package; the block must ignore it.
	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned ITEMS_PER_PHASE = 600;
	localparam int unsigned TAIL_CYCLES = 64;

	typedef struct {
		cmd_t c;
		bit   typed;
		pix_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	cmd_t cmd = '0;
	logic pix_valid;
	logic pix_ready = 1'b0;
	pix_t pix;

	// Predicted breathing state.
	logic [7:0]  base_r, base_g, base_b;
	logic [15:0] ramp_pos, ramp_top;
	bit          ramp_down, breathing;

	pix_t        word_expect [$];
	int unsigned errors = 0;
	int unsigned live_items = 0;
	int unsigned cycles = 0;
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	bit          long_hold = 1'b0;

	led_breath_ramp_controller_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic logic [7:0] dim_level(input logic [7:0] lvl);
		logic [31:0] prod;
		if (ramp_top == '0)
			return '0;
		prod = 32'(lvl) * 32'(ramp_pos);
		return 8'(prod / 32'(ramp_top));
	endfunction

	function automatic pix_t ramp_word();
		pix_t p;
		p.red_out   = dim_level(base_r);
		p.green_out = dim_level(base_g);
		p.blue_out  = dim_level(base_b);
		return p;
	endfunction

	// Returns 1 when the command produces a word; ignored marks commands that
	// change nothing at all.
	function automatic bit breath_predict(input cmd_t c, output pix_t p, output bit ignored);
		p = '0;
		ignored = 1'b0;
		case (c.opcode)
		OP_STEADY: begin
			breathing   = 1'b0;
			p.red_out   = c.red_in;
			p.green_out = c.green_in;
			p.blue_out  = c.blue_in;
			return 1'b1;
		end
		OP_BREATH: begin
			base_r    = c.red_in;
			base_g    = c.green_in;
			base_b    = c.blue_in;
			ramp_top  = c.ramp_len_in;
			ramp_pos  = '0;
			ramp_down = 1'b0;
			breathing = 1'b1;
			return 1'b0;
		end
		OP_TICK: begin
			if (!breathing) begin
				ignored = 1'b1;
				return 1'b0;
			end
			if (!ramp_down) begin
				if (ramp_pos < ramp_top) begin
					p = ramp_word();
					ramp_pos = ramp_pos + 16'd1;
					return 1'b1;
				end
				ramp_down = 1'b1;
				return 1'b0;
			end
			if (ramp_pos != '0) begin
				p = ramp_word();
				ramp_pos = ramp_pos - 16'd1;
				return 1'b1;
			end
			ramp_down = 1'b0;
			return 1'b0;
		end
		default: begin
			ignored = 1'b1;
			return 1'b0;
		end
		endcase
	endfunction

	function automatic cmd_t cmd_word(input logic [1:0] op, input logic [7:0] r, g, b,
			input logic [15:0] len);
		cmd_t c;
		c.opcode      = op;
		c.red_in      = r;
		c.green_in    = g;
		c.blue_in     = b;
		c.ramp_len_in = len;
		return c;
	endfunction

	function automatic logic [7:0] pick_level();
		int unsigned k;
		k = $urandom_range(99);
		if (k < 15)
			return 8'h00;
		if (k < 30)
			return 8'hff;
		return 8'($urandom);
	endfunction

	// Mostly short ramps so that whole triangles are walked; a few long ones.
	function automatic logic [15:0] pick_len();
		int unsigned k;
		k = $urandom_range(99);
		if (k < 60)
			return 16'($urandom_range(12));
		if (k < 80)
			return 16'($urandom_range(300, 13));
		if (k < 90)
			return 16'($urandom);
		if (k < 95)
			return 16'hffff;
		return 16'h0000;
	endfunction

	function automatic cmd_t rand_cmd(input logic [1:0] op);
		return cmd_word(op, pick_level(), pick_level(), pick_level(), 16'($urandom));
	endfunction

	task automatic send_cmd(input cmd_t c, input bit typed = 1'b0, input pix_t want = '0);
		pix_t p;
		bit   emits;
		bit   ignored;
		while ($urandom_range(99) < tx_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd       <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		emits = breath_predict(c, p, ignored);
		if (typed)
			p = want;
		if (emits)
			word_expect.push_back(p);
		if (!ignored)
			live_items++;
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (word_expect.size() != 0)
			@(posedge clk);
	endtask

	// A breathing command followed by a run of ticks, with the odd steady or
	// unused command mixed in; the rest is loose commands.
	task automatic random_burst();
		cmd_t        c;
		int unsigned k;
		int unsigned n;
		k = $urandom_range(99);
		if (k < 70) begin
			c = rand_cmd(OP_BREATH);
			c.ramp_len_in = pick_len();
			send_cmd(c);
			if (c.ramp_len_in < 25)
				n = $urandom_range(2 * c.ramp_len_in + 4, 1);
			else
				n = $urandom_range(50, 1);
			repeat (n) begin
				k = $urandom_range(99);
				send_cmd(rand_cmd(k < 3 ? OP_SPARE : k < 6 ? OP_STEADY : OP_TICK));
			end
		end else if (k < 85) begin
			send_cmd(rand_cmd(OP_STEADY));
		end else if (k < 93) begin
			repeat ($urandom_range(8, 1))
				send_cmd(rand_cmd(OP_TICK));
		end else begin
			send_cmd(rand_cmd(OP_SPARE));
		end
	endtask

	task automatic flag_word(input string why, input pix_t want, input pix_t got);
		if (errors < 10)
			$display("%s: expected r=%02h g=%02h b=%02h, got r=%02h g=%02h b=%02h", why,
				want.red_out, want.green_out, want.blue_out,
				got.red_out, got.green_out, got.blue_out);
		errors++;
	endtask

	// Word receiver and checker.
	initial begin
		pix_t        want;
		int unsigned hold_left;
		bit          hold_spent;
		hold_left  = 0;
		hold_spent = 1'b0;
		forever begin
			@(posedge clk);
			if (pix_valid && pix_ready) begin
				if (word_expect.size() == 0) begin
					flag_word("unexpected word", '0, pix);
				end else begin
					want = word_expect.pop_front();
					if (pix.red_out !== want.red_out || pix.green_out !== want.green_out ||
							pix.blue_out !== want.blue_out)
						flag_word("word mismatch", want, pix);
				end
			end
			if (long_hold && !hold_spent) begin
				hold_left  = HOLD_CYCLES;
				hold_spent = 1'b1;
			end
			if (hold_left != 0) begin
				pix_ready <= 1'b0;
				hold_left--;
			end else begin
				pix_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		dir_row_t    dir_rows [$];
		cmd_t        c;
		int unsigned ph;
		base_r    = '0;
		base_g    = '0;
		base_b    = '0;
		ramp_pos  = '0;
		ramp_top  = '0;
		ramp_down = 1'b0;
		breathing = 1'b0;
		dir_rows = '{
			'{cmd_word(OP_TICK,   8'h00, 8'h00, 8'h00, 16'h0000), 1'b0, 24'h000000},
			'{cmd_word(OP_SPARE,  8'hff, 8'hff, 8'hff, 16'hffff), 1'b0, 24'h000000},
			'{cmd_word(OP_STEADY, 8'hff, 8'h00, 8'hff, 16'h0000), 1'b1, 24'hff00ff},
			'{cmd_word(OP_STEADY, 8'h00, 8'hff, 8'h00, 16'hffff), 1'b1, 24'h00ff00},
			// Zero ramp length: ticks only flip the direction.
			'{cmd_word(OP_BREATH, 8'hff, 8'hff, 8'hff, 16'h0000), 1'b0, 24'h000000},
			'{cmd_word(OP_TICK,   8'h00, 8'h00, 8'h00, 16'h0000), 1'b0, 24'h000000},
			'{cmd_word(OP_TICK,   8'hff, 8'hff, 8'hff, 16'hffff), 1'b0, 24'h000000},
			// A full triangle of length two, both turning points included.
			'{cmd_word(OP_BREATH, 8'hff, 8'h80, 8'h01, 16'h0002), 1'b0, 24'h000000},
			'{cmd_word(OP_TICK,   8'h00, 8'h00, 8'h00, 16'h0000), 1'b1, 24'h000000},
			'{cmd_word(OP_TICK,   8'h00, 8'h00, 8'h00, 16'h0000), 1'b1, 24'h7f4000},
			'{cmd_word(OP_TICK,   8'h00, 8'h00, 8'h00, 16'h0000), 1'b0, 24'h000000},
			'{cmd_word(OP_TICK,   8'h00, 8'h00, 8'h00, 16'h0000), 1'b1, 24'hff8001},
			'{cmd_word(OP_TICK,   8'h00, 8'h00, 8'h00, 16'h0000), 1'b1, 24'h7f4000},
			'{cmd_word(OP_TICK,   8'h00, 8'h00, 8'h00, 16'h0000), 1'b0, 24'h000000},
			'{cmd_word(OP_TICK,   8'h00, 8'h00, 8'h00, 16'h0000), 1'b1, 24'h000000},
			'{cmd_word(OP_STEADY, 8'h12, 8'h34, 8'h56, 16'h0000), 1'b1, 24'h123456},
			'{cmd_word(OP_TICK,   8'hff, 8'hff, 8'hff, 16'hffff), 1'b0, 24'h000000},
			'{cmd_word(OP_BREATH, 8'hff, 8'hff, 8'hff, 16'hffff), 1'b0, 24'h000000},
			'{cmd_word(OP_TICK,   8'h00, 8'h00, 8'h00, 16'h0000), 1'b1, 24'h000000},
			'{cmd_word(OP_TICK,   8'h00, 8'h00, 8'h00, 16'h0000), 1'b1, 24'h000000},
			'{cmd_word(OP_BREATH, 8'h01, 8'hfe, 8'h80, 16'h0001), 1'b0, 24'h000000},
			'{cmd_word(OP_TICK,   8'h00, 8'h00, 8'h00, 16'h0000), 1'b1, 24'h000000},
			'{cmd_word(OP_TICK,   8'h00, 8'h00, 8'h00, 16'h0000), 1'b0, 24'h000000},
			'{cmd_word(OP_TICK,   8'h00, 8'h00, 8'h00, 16'h0000), 1'b1, 24'h01fe80},
			'{cmd_word(OP_TICK,   8'h00, 8'h00, 8'h00, 16'h0000), 1'b0, 24'h000000},
			'{cmd_word(OP_TICK,   8'h00, 8'h00, 8'h00, 16'h0000), 1'b1, 24'h000000}
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (ph = 0; ph < 3; ph++) begin
			tx_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 58 : 0;
			rx_idle_pct = (ph == 0) ? 58 : (ph == 1) ? 7 : 0;
			if (ph == 0) begin
				foreach (dir_rows[i])
					send_cmd(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].want);
				wait_drained();
			end
			if (ph == 2) begin
				// The receiver stalls while a long ramp keeps ticking, so the
				// block backs up and drops cmd_ready.
				long_hold = 1'b1;
				c = rand_cmd(OP_BREATH);
				c.ramp_len_in = 16'd2000;
				send_cmd(c);
				repeat (40)
					send_cmd(rand_cmd(OP_TICK));
				wait_drained();
			end
			while (live_items < ITEMS_PER_PHASE * (ph + 1))
				random_burst();
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		errors += word_expect.size();
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
